FILE: design/dlpd_pkg.sv
// Shared types and constants for the debug line program decoder.
// Record kinds, opcode codes, register indexes and the special-opcode split.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dlpd_pkg;

	typedef enum logic [3:0] {
		KIND_LINE      = 4'd0,
		KIND_LOCAL     = 4'd1,
		KIND_LOCAL_EXT = 4'd2,
		KIND_END_LOCAL = 4'd3,
		KIND_RESTART   = 4'd4,
		KIND_PROLOGUE  = 4'd5,
		KIND_EPILOGUE  = 4'd6,
		KIND_FILE      = 4'd7,
		KIND_END       = 4'd8,
		KIND_BAD_OP    = 4'd9,
		KIND_LINE_ZERO = 4'd10
	} kind_t;

	typedef logic [3:0] opcode_t;

	localparam opcode_t OP_END_SEQ     = 4'd0;
	localparam opcode_t OP_ADVANCE_PC  = 4'd1;
	localparam opcode_t OP_ADVANCE_LN  = 4'd2;
	localparam opcode_t OP_START_LOCAL = 4'd3;
	localparam opcode_t OP_LOCAL_EXT   = 4'd4;
	localparam opcode_t OP_END_LOCAL   = 4'd5;
	localparam opcode_t OP_RESTART     = 4'd6;
	localparam opcode_t OP_PROLOGUE    = 4'd7;
	localparam opcode_t OP_EPILOGUE    = 4'd8;
	localparam opcode_t OP_SET_FILE    = 4'd9;

	localparam logic [7:0]  FIRST_SPECIAL = 8'h0A;
	localparam logic [31:0] NONE_INDEX    = 32'hFFFF_FFFF;

	localparam logic REG_START_ADDRESS = 1'b0;
	localparam logic REG_START_LINE    = 1'b1;

	typedef struct packed {
		logic [4:0] addr_steps; // adj div 15
		logic [3:0] line_step;  // adj mod 15
	} special_t;

	// adj div 15 by reciprocal 137/2048, exact for adj below 256
	function automatic special_t split_special(input logic [7:0] adj);
		logic [15:0] prod;
		logic [4:0]  quo;
		logic [7:0]  rem;
		special_t    res;
		prod = 16'(adj) * 16'd137;
		quo = prod[15:11];
		rem = adj - 8'(quo) * 8'd15;
		res.addr_steps = quo;
		res.line_step = rem[3:0];
		return res;
	endfunction

endpackage

`default_nettype wire

FILE: design/debug_line_program_decoder_top.sv
// Debug line program decoder, top level.
// Byte-in, record-out decoder with one output register; uses dlpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Takes one program byte per cycle on s_axis and keeps the running address and
// line. Each byte is decoded in a single pass and its record, if any, lands in
// the output register on the next edge. A new byte is taken every cycle unless
// the output register holds a record the sink has not taken yet. Opcode 0 ends
// the program (record with tlast); the next byte reloads address and line from
// the start registers. Operands longer than MAX_LEB_BYTES bytes are cut off;
// LEB128 bits above 32 are dropped. Start registers are written through cfg_*.
module debug_line_program_decoder_top import dlpd_pkg::*; #(
	parameter int MAX_LEB_BYTES = 5
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic         cfg_index,
	input  wire logic [31:0]  cfg_data,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [7:0]   s_axis_tdata,  // [7:0] program_byte
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [199:0]      m_axis_tdata,  // at_address, line_value, register_number,
	                                         // name_index, type_index, signature_index,
	                                         // line_is_zero, zero pad
	output logic [3:0]        m_axis_tuser,  // [3:0] kind
	output logic              m_axis_tlast
);

	localparam int LebLimit = 7 * (MAX_LEB_BYTES - 1);
	localparam int SW = $clog2(LebLimit + 1);

	logic [31:0]   start_addr_q, start_line_q;
	logic [31:0]   addr_q, line_q;
	opcode_t       pend_q;
	logic [1:0]    slot_q;
	logic [31:0]   acc_q;
	logic [SW-1:0] shift_q;
	logic [31:0]   held_q [3];
	logic          done_q;

	logic          out_valid_q;
	kind_t         kind_q;
	logic [31:0]   at_addr_q, line_val_q, reg_num_q, name_q, type_q, sig_q;
	logic          zero_q, last_q;

	logic          accept;
	logic [7:0]    b;

	// effective state after an optional program reload
	logic [31:0]   e_addr, e_line, e_acc;
	opcode_t       e_pend;
	logic [1:0]    e_slot;
	logic [SW-1:0] e_shift;

	logic [31:0]   n_addr, n_line, n_acc;
	opcode_t       n_pend;
	logic [1:0]    n_slot;
	logic [SW-1:0] n_shift;
	logic          n_done;
	logic          hold_we;

	logic          emit;
	kind_t         r_kind;
	logic [31:0]   r_reg, r_name, r_type, r_sig;
	logic          r_zero, r_last;

	logic [5:0]    sh6;
	logic [38:0]   shifted;
	logic [31:0]   acc_new, sign_mask, v;
	logic [1:0]    op_count;
	special_t      sp;
	logic [31:0]   line_adv;

	assign b = s_axis_tdata;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept = s_axis_tvalid && s_axis_tready;

	always_comb begin
		e_addr  = done_q ? start_addr_q : addr_q;
		e_line  = done_q ? start_line_q : line_q;
		e_pend  = done_q ? OP_END_SEQ : pend_q;
		e_slot  = done_q ? 2'd0 : slot_q;
		e_acc   = done_q ? 32'd0 : acc_q;
		e_shift = done_q ? '0 : shift_q;

		sh6 = 6'(e_shift);
		shifted = {32'd0, b[6:0]} << sh6[4:0];
		acc_new = sh6[5] ? e_acc : (e_acc | shifted[31:0]);
		sign_mask = (e_pend == OP_ADVANCE_LN && b[6] && sh6 < 6'd25) ?
			(32'hFFFF_FFFF << (sh6[4:0] + 5'd7)) : 32'd0;
		v = acc_new | sign_mask;

		case (e_pend)
			OP_START_LOCAL: op_count = 2'd3;
			OP_LOCAL_EXT:   op_count = 2'd0; // four operands, counted modulo 4
			default:        op_count = 2'd1;
		endcase

		sp = split_special(b - FIRST_SPECIAL);
		line_adv = e_line + {28'd0, sp.line_step} - 32'd4;

		n_addr  = e_addr;
		n_line  = e_line;
		n_acc   = e_acc;
		n_pend  = e_pend;
		n_slot  = e_slot;
		n_shift = e_shift;
		n_done  = 1'b0;
		hold_we = 1'b0;
		emit    = 1'b0;
		r_kind  = KIND_LINE;
		r_reg   = 32'd0;
		r_name  = NONE_INDEX;
		r_type  = NONE_INDEX;
		r_sig   = NONE_INDEX;
		r_zero  = 1'b0;
		r_last  = 1'b0;

		if (e_pend == OP_END_SEQ) begin
			if (b >= FIRST_SPECIAL) begin
				n_line = line_adv;
				n_addr = e_addr + {26'd0, sp.addr_steps, 1'b0};
				emit = 1'b1;
				r_kind = KIND_LINE;
				r_zero = (line_adv == 32'd0);
			end else if (b == {4'd0, OP_END_SEQ}) begin
				n_done = 1'b1;
				emit = 1'b1;
				r_kind = KIND_END;
				r_last = 1'b1;
			end else if (b == {4'd0, OP_PROLOGUE}) begin
				emit = 1'b1;
				r_kind = KIND_PROLOGUE;
			end else if (b == {4'd0, OP_EPILOGUE}) begin
				emit = 1'b1;
				r_kind = KIND_EPILOGUE;
			end else begin
				n_pend  = b[3:0];
				n_slot  = 2'd0;
				n_acc   = 32'd0;
				n_shift = '0;
			end
		end else if (b[7] && e_shift < SW'(LebLimit)) begin
			n_acc = acc_new;
			n_shift = e_shift + SW'(7);
		end else begin
			n_acc = 32'd0;
			n_shift = '0;
			if (e_slot + 2'd1 != op_count) begin
				hold_we = 1'b1;
				n_slot = e_slot + 2'd1;
			end else begin
				n_pend = OP_END_SEQ;
				n_slot = 2'd0;
				case (e_pend)
					OP_ADVANCE_PC: begin
						n_addr = e_addr + v;
					end
					OP_ADVANCE_LN: begin
						n_line = e_line + v;
						if (e_line + v == 32'd0) begin
							emit = 1'b1;
							r_kind = KIND_LINE_ZERO;
							r_zero = 1'b1;
						end
					end
					OP_START_LOCAL: begin
						emit = 1'b1;
						r_kind = KIND_LOCAL;
						r_reg = held_q[0];
						r_name = held_q[1] - 32'd1;
						r_type = v - 32'd1;
					end
					OP_LOCAL_EXT: begin
						emit = 1'b1;
						r_kind = KIND_LOCAL_EXT;
						r_reg = held_q[0];
						r_name = held_q[1] - 32'd1;
						r_type = held_q[2] - 32'd1;
						r_sig = v - 32'd1;
					end
					OP_END_LOCAL: begin
						emit = 1'b1;
						r_kind = KIND_END_LOCAL;
						r_reg = v;
					end
					OP_RESTART: begin
						emit = 1'b1;
						r_kind = KIND_RESTART;
						r_reg = v;
					end
					default: begin
						emit = 1'b1;
						r_kind = KIND_FILE;
						r_reg = v;
					end
				endcase
			end
		end
	end

	// start registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_addr_q <= 32'd0;
			start_line_q <= 32'd1;
		end else if (cfg_we) begin
			if (cfg_index == REG_START_ADDRESS) start_addr_q <= cfg_data;
			if (cfg_index == REG_START_LINE) start_line_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= 32'd0;
			line_q  <= 32'd1;
			pend_q  <= OP_END_SEQ;
			slot_q  <= 2'd0;
			acc_q   <= 32'd0;
			shift_q <= '0;
			done_q  <= 1'b1;
		end else if (accept) begin
			addr_q  <= n_addr;
			line_q  <= n_line;
			pend_q  <= n_pend;
			slot_q  <= n_slot;
			acc_q   <= n_acc;
			shift_q <= n_shift;
			done_q  <= n_done;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hold_we) held_q[e_slot] <= v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			kind_q     <= r_kind;
			at_addr_q  <= n_addr;
			line_val_q <= n_line;
			reg_num_q  <= r_reg;
			name_q     <= r_name;
			type_q     <= r_type;
			sig_q      <= r_sig;
			zero_q     <= r_zero;
			last_q     <= r_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = kind_q;
	assign m_axis_tlast  = last_q;
	assign m_axis_tdata  = {7'd0, zero_q, sig_q, type_q, name_q, reg_num_q,
		line_val_q, at_addr_q};

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_axis_tready)
		else $error("input stalled with empty output register");

	a_last_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && last_q |-> kind_q == KIND_END)
		else $error("tlast on a record other than end of sequence");

	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && zero_q |-> line_val_q == 32'd0)
		else $error("line_is_zero set with nonzero line");

	a_pending_op: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != OP_PROLOGUE && pend_q != OP_EPILOGUE && pend_q <= OP_SET_FILE)
		else $error("pending opcode holds an opcode without operands");

	a_done_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		accept && emit && r_kind == KIND_END |=> done_q)
		else $error("end record did not finish the program");

endmodule

`default_nettype wire

FILE: sim/debug_line_program_decoder_top_tb.sv
// Testbench for debug_line_program_decoder_top: streams program bytes, predicts every record.
// Uses dlpd_pkg for kinds, opcodes and register indexes; needs only the design sources.
// Byte predictor and record queue sit in a small class; plain tasks drive the stream.
`timescale 1ns / 1ps

module debug_line_program_decoder_top_tb import dlpd_pkg::*;;

	localparam int LEB_BYTE_LIMIT = 5;
	localparam int LINE_RANGE = 15;
	localparam int PHASE_BYTES = 125;
	localparam int DIRECTED_COUNT = 30;

	typedef struct {
		kind_t       kind;
		logic [31:0] at_address;
		logic [31:0] line_value;
		logic [31:0] register_number;
		logic [31:0] name_index;
		logic [31:0] type_index;
		logic [31:0] signature_index;
		logic        line_is_zero;
		logic        last;
	} line_record_t;

	class line_record_tracker;
		bit [31:0]    start_addr = 32'd0;
		bit [31:0]    start_ln = 32'd1;
		bit [31:0]    addr;
		bit [31:0]    ln;
		opcode_t      pend_op;
		int unsigned  slot;
		bit [31:0]    acc;
		int unsigned  shift;
		bit [31:0]    held [3];
		bit           done = 1'b1;
		line_record_t records_due [$];
		int           mismatches = 0;

		function void set_start(logic idx, bit [31:0] value);
			if (idx == REG_START_ADDRESS)
				start_addr = value;
			else
				start_ln = value;
		endfunction

		function int pending();
			return records_due.size();
		endfunction

		function void push_record(kind_t k, bit [31:0] r, bit [31:0] n, bit [31:0] t,
				bit [31:0] s, bit z, bit l);
			line_record_t rec;
			rec.kind = k;
			rec.at_address = addr;
			rec.line_value = ln;
			rec.register_number = r;
			rec.name_index = n;
			rec.type_index = t;
			rec.signature_index = s;
			rec.line_is_zero = z;
			rec.last = l;
			records_due.insert(records_due.size(), rec);
		endfunction

		function void complete_op(bit [31:0] v);
			case (pend_op)
				OP_ADVANCE_PC: begin
					addr += v;
				end
				OP_ADVANCE_LN: begin
					ln += v;
					if (ln == 32'd0)
						push_record(KIND_LINE_ZERO, 0, NONE_INDEX, NONE_INDEX, NONE_INDEX, 1, 0);
				end
				OP_START_LOCAL: begin
					push_record(KIND_LOCAL, held[0], held[1] - 1, v - 1, NONE_INDEX, 0, 0);
				end
				OP_LOCAL_EXT: begin
					push_record(KIND_LOCAL_EXT, held[0], held[1] - 1, held[2] - 1, v - 1, 0, 0);
				end
				OP_END_LOCAL: begin
					push_record(KIND_END_LOCAL, v, NONE_INDEX, NONE_INDEX, NONE_INDEX, 0, 0);
				end
				OP_RESTART: begin
					push_record(KIND_RESTART, v, NONE_INDEX, NONE_INDEX, NONE_INDEX, 0, 0);
				end
				default: begin
					push_record(KIND_FILE, v, NONE_INDEX, NONE_INDEX, NONE_INDEX, 0, 0);
				end
			endcase
		endfunction

		// Advances the decoder state by one accepted byte, queueing any record it makes.
		function void absorb_byte(bit [7:0] b);
			bit [7:0]    adj;
			bit [63:0]   wide;
			bit [31:0]   v;
			int unsigned count;
			if (done) begin
				addr = start_addr;
				ln = start_ln;
				pend_op = OP_END_SEQ;
				slot = 0;
				acc = 0;
				shift = 0;
				done = 1'b0;
			end
			if (pend_op == OP_END_SEQ) begin
				if (b >= FIRST_SPECIAL) begin
					adj = b - FIRST_SPECIAL;
					ln += 32'(adj % LINE_RANGE) - 32'd4;
					addr += 32'(adj / LINE_RANGE) * 32'd2;
					push_record(KIND_LINE, 0, NONE_INDEX, NONE_INDEX, NONE_INDEX, ln == 0, 0);
				end else if (b == 8'(OP_END_SEQ)) begin
					done = 1'b1;
					push_record(KIND_END, 0, NONE_INDEX, NONE_INDEX, NONE_INDEX, 0, 1);
				end else if (b == 8'(OP_PROLOGUE)) begin
					push_record(KIND_PROLOGUE, 0, NONE_INDEX, NONE_INDEX, NONE_INDEX, 0, 0);
				end else if (b == 8'(OP_EPILOGUE)) begin
					push_record(KIND_EPILOGUE, 0, NONE_INDEX, NONE_INDEX, NONE_INDEX, 0, 0);
				end else begin
					pend_op = b[3:0];
					slot = 0;
					acc = 0;
					shift = 0;
				end
				return;
			end
			if (shift < 32) begin
				wide = 64'(b[6:0]) << shift;
				acc |= wide[31:0];
			end
			if (b[7] && (shift / 7 + 1 < LEB_BYTE_LIMIT)) begin
				shift += 7;
				return;
			end
			v = acc;
			// only the line advance operand is signed
			if (pend_op == OP_ADVANCE_LN && b[6] && shift + 7 < 32)
				v |= 32'hFFFF_FFFF << (shift + 7);
			acc = 0;
			shift = 0;
			count = (pend_op == OP_START_LOCAL) ? 3 : (pend_op == OP_LOCAL_EXT) ? 4 : 1;
			if (slot + 1 < count) begin
				held[slot] = v;
				slot++;
				return;
			end
			complete_op(v);
			pend_op = OP_END_SEQ;
			slot = 0;
		endfunction

		function void match_record(logic [199:0] data, logic [3:0] user, logic tlast);
			line_record_t exp;
			if (records_due.size() == 0) begin
				$error("unexpected record: kind %0d", user);
				mismatches++;
				return;
			end
			exp = records_due.pop_front();
			if (user !== 4'(exp.kind)) begin
				$error("kind: expected %0d, got %0d", exp.kind, user);
				mismatches++;
			end
			if (data[31:0] !== exp.at_address) begin
				$error("at_address: expected %h, got %h", exp.at_address, data[31:0]);
				mismatches++;
			end
			if (data[63:32] !== exp.line_value) begin
				$error("line_value: expected %h, got %h", exp.line_value, data[63:32]);
				mismatches++;
			end
			if (data[95:64] !== exp.register_number) begin
				$error("register_number: expected %h, got %h", exp.register_number,
					data[95:64]);
				mismatches++;
			end
			if (data[127:96] !== exp.name_index) begin
				$error("name_index: expected %0d, got %0d", $signed(exp.name_index),
					$signed(data[127:96]));
				mismatches++;
			end
			if (data[159:128] !== exp.type_index) begin
				$error("type_index: expected %0d, got %0d", $signed(exp.type_index),
					$signed(data[159:128]));
				mismatches++;
			end
			if (data[191:160] !== exp.signature_index) begin
				$error("signature_index: expected %0d, got %0d", $signed(exp.signature_index),
					$signed(data[191:160]));
				mismatches++;
			end
			if (data[192] !== exp.line_is_zero) begin
				$error("line_is_zero: expected %0d, got %0d", exp.line_is_zero, data[192]);
				mismatches++;
			end
			if (tlast !== exp.last) begin
				$error("last: expected %0d, got %0d", exp.last, tlast);
				mismatches++;
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic         cfg_index;
	logic [31:0]  cfg_data;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata;   // [7:0] program_byte
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [199:0] m_axis_tdata;   // at_address, line_value, register_number, name_index,
	                              // type_index, signature_index, line_is_zero, zero pad
	logic [3:0]   m_axis_tuser;   // [3:0] kind
	logic         m_axis_tlast;

	line_record_tracker tracker = new();
	int  bytes_taken = 0;
	int  stim_bytes = 0;
	bit  calm = 1'b0;

	bit [7:0] directed_prog [0:DIRECTED_COUNT-1] = '{
		8'h0A, 8'hFF, 8'(OP_PROLOGUE), 8'(OP_EPILOGUE),
		8'(OP_ADVANCE_PC), 8'h85, 8'h01,
		8'(OP_ADVANCE_LN), 8'h02,                 // line drops to zero
		8'h0E,                                    // line record with zero flag
		8'(OP_START_LOCAL), 8'h00, 8'h80, 8'h01, 8'h00,
		8'(OP_LOCAL_EXT), 8'h01, 8'h02, 8'h03, 8'h00,
		8'(OP_END_LOCAL), 8'h7F, 8'(OP_RESTART), 8'h00,
		8'(OP_SET_FILE), 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF  // cut off at five bytes
	};

	debug_line_program_decoder_top #(
		.MAX_LEB_BYTES(LEB_BYTE_LIMIT)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				tracker.absorb_byte(s_axis_tdata);
				bytes_taken++;
			end
			if (m_axis_tvalid && m_axis_tready)
				tracker.match_record(m_axis_tdata, m_axis_tuser, m_axis_tlast);
		end
	end

	// Sink: random stall bursts plus one long hold-off so the block backs up.
	initial begin
		int stall_left;
		bit long_hold_done;
		bit ready_next;
		stall_left = 0;
		long_hold_done = 1'b0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				ready_next = 1'b0;
			end else if (!long_hold_done && bytes_taken >= 60) begin
				long_hold_done = 1'b1;
				stall_left = 199;
				ready_next = 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 14) - 1;
				ready_next = 1'b0;
			end else begin
				ready_next = 1'b1;
			end
			m_axis_tready <= ready_next;
		end
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	task automatic send_byte(bit [7:0] b);
		if (!calm && $urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 14)) @(negedge clk) s_axis_tvalid <= 1'b0;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		stim_bytes++;
	endtask

	task automatic write_start(logic idx, bit [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		tracker.set_start(idx, value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		@(negedge clk) s_axis_tvalid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	// LEB128 of v in nb bytes (1..5); in a fifth byte the bits above 32 are random
	task automatic send_leb(bit [31:0] v, int nb);
		bit [6:0] grp;
		for (int i = 0; i < nb; i++) begin
			grp = 7'(v >> (7 * i));
			if (i == 4)
				grp[6:4] = 3'($urandom);
			send_byte({i < nb - 1, grp});
		end
	endtask

	task automatic send_random_operand();
		int r;
		r = $urandom_range(0, 9);
		send_leb($urandom, (r < 6) ? 1 : (r < 8) ? 2 : (r < 9) ? $urandom_range(3, 4) : 5);
	endtask

	task automatic random_instruction();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			send_byte(8'($urandom_range(FIRST_SPECIAL, 255)));
		end else if (r < 45) begin
			send_byte(8'(OP_END_SEQ));
		end else if (r < 50) begin
			send_byte($urandom_range(0, 1) ? 8'(OP_PROLOGUE) : 8'(OP_EPILOGUE));
		end else if (r < 58) begin
			send_byte(8'(OP_ADVANCE_PC));
			send_random_operand();
		end else if (r < 66) begin
			send_byte(8'(OP_ADVANCE_LN));
			send_random_operand();
		end else if (r < 70) begin
			// advance that brings the line exactly to zero
			send_byte(8'(OP_ADVANCE_LN));
			send_leb(-tracker.ln, 5);
		end else if (r < 78) begin
			send_byte(8'(OP_START_LOCAL));
			repeat (3) send_random_operand();
		end else if (r < 84) begin
			send_byte(8'(OP_LOCAL_EXT));
			repeat (4) send_random_operand();
		end else if (r < 88) begin
			case ($urandom_range(0, 2))
				0: send_byte(8'(OP_END_LOCAL));
				1: send_byte(8'(OP_RESTART));
				default: send_byte(8'(OP_SET_FILE));
			endcase
			send_random_operand();
		end else if (r < 95) begin
			// overlong operand: bytes past the limit are decoded as opcodes
			send_byte(8'($urandom_range(OP_ADVANCE_PC, OP_SET_FILE)));
			n = $urandom_range(6, 8);
			for (int i = 0; i < n; i++)
				send_byte({i < n - 1, 7'($urandom)});
		end else begin
			send_byte(8'($urandom));
		end
	endtask

	task automatic run_phase();
		int target;
		target = stim_bytes + PHASE_BYTES;
		while (stim_bytes < target)
			random_instruction();
		send_byte(8'(OP_END_SEQ));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = 32'd0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'd0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED_COUNT; i++)
			send_byte(directed_prog[i]);
		run_phase();
		wait_drained();

		write_start(REG_START_ADDRESS, 32'hFFFF_FFFF);
		write_start(REG_START_LINE, 32'hFFFF_FFFF);
		run_phase();
		wait_drained();

		write_start(REG_START_ADDRESS, 32'd0);
		write_start(REG_START_LINE, 32'd0);
		run_phase();
		wait_drained();

		write_start(REG_START_ADDRESS, $urandom);
		write_start(REG_START_LINE, $urandom);
		calm = 1'b1;
		run_phase();
		wait_drained();

		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
